### sv/vtu_pkg.sv
package vtu_pkg;

  // Fixed field widths of the item.
  localparam int DATA_W    = 32;
  localparam int ANGLE_W   = 16;
  localparam int CMD_W     = 3;

  // Fixed-point formats.
  localparam int FRAC_BITS = 16;
  localparam int ROT_SHIFT = 15;
  localparam int MAG_W     = 16;
  localparam int COEF_W    = MAG_W + 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PROD1_W   = COEF_W + DATA_W;

  // Sine table defaults and series constants.
  localparam int SINE_TABLE_ENTRIES_DEF = 256;
  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
  localparam logic [63:0] UNIT_Q15      = 64'd32768;

  localparam logic signed [DATA_W-1:0] DATA_ONE       = DATA_W'(1);
  localparam logic signed [COEF_W-1:0] COEF_ONE       = COEF_W'(1);
  localparam logic signed [COEF_W-1:0] COEF_MINUS_ONE = {COEF_W{1'b1}};
  localparam logic signed [DATA_W-1:0] DATA_MAX       = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN       = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_SUB    = 3'd1,
    CMD_ROT_XY = 3'd2,
    CMD_ROT_XZ = 3'd3,
    CMD_ROT_YZ = 3'd4,
    CMD_SCALE  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_ROT   = 2'd1,
    SH_SCALE = 2'd2
  } shift_sel_t;

  // Operands of one lane: m0 * x0 + m1 * x1, then an optional rounding shift.
  typedef struct packed {
    logic signed [DATA_W-1:0] m0;
    logic signed [DATA_W-1:0] x0;
    logic signed [COEF_W-1:0] m1;
    logic signed [DATA_W-1:0] x1;
    shift_sel_t               sh;
  } lane_op_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clip;
  } lane_res_t;

endpackage

### sv/vtu_sine_rom.sv
module vtu_sine_rom import vtu_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ANGLE_W-1:0]       angle,
  output logic signed [COEF_W-1:0] sin_q15,
  output logic signed [COEF_W-1:0] cos_q15
);

  localparam int IDX_W   = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int PHASE_W = ANGLE_W - 2;
  localparam int MUL_W   = PHASE_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SINE_TABLE_ENTRIES);

  typedef logic [MAG_W-1:0] mag_tbl_t [SINE_TABLE_ENTRIES+1];

  // Quarter-wave magnitudes, built at elaboration with a Q30 Taylor series.
  function automatic mag_tbl_t build_table();
    mag_tbl_t           t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] acc;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_ENTRIES;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = '0;
      end
      r = ($unsigned(acc) + 64'd16384) >> 15;
      if (r > UNIT_Q15) begin
        r = UNIT_Q15;
      end
      t[k] = r[MAG_W-1:0];
    end
    return t;
  endfunction

  localparam mag_tbl_t SINE_MAG = build_table();

  logic [1:0]         quad_s;
  logic [1:0]         quad_c;
  logic [MUL_W-1:0]   scaled;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   addr_s;
  logic [IDX_W-1:0]   addr_c;
  logic [MAG_W-1:0]   mag_s_r;
  logic [MAG_W-1:0]   mag_c_r;
  logic               neg_s_r;
  logic               neg_c_r;
  logic signed [COEF_W-1:0] ms;
  logic signed [COEF_W-1:0] mc;

  // Cosine is the sine a quarter turn later: same phase, next quadrant.
  always_comb begin
    quad_s = angle[ANGLE_W-1 -: 2];
    quad_c = quad_s + 2'd1;
    scaled = MUL_W'(angle[PHASE_W-1:0]) * MUL_W'(SINE_TABLE_ENTRIES);
    idx    = scaled[PHASE_W +: IDX_W];
    addr_s = quad_s[0] ? (LAST_IDX - idx) : idx;
    addr_c = quad_c[0] ? (LAST_IDX - idx) : idx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_s_r <= SINE_MAG[addr_s];
      mag_c_r <= SINE_MAG[addr_c];
      neg_s_r <= quad_s[1];
      neg_c_r <= quad_c[1];
    end
  end

  always_comb begin
    ms      = $signed({1'b0, mag_s_r});
    mc      = $signed({1'b0, mag_c_r});
    sin_q15 = neg_s_r ? -ms : ms;
    cos_q15 = neg_c_r ? -mc : mc;
  end

endmodule

### sv/vtu_lane.sv
module vtu_lane import vtu_pkg::*; (
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  lane_op_t  op,
  output lane_res_t res
);

  logic signed [DATA_W-1:0]  m0;
  logic signed [DATA_W-1:0]  x0;
  logic signed [COEF_W-1:0]  m1;
  logic signed [DATA_W-1:0]  x1;
  logic signed [PROD_W-1:0]  mul0;
  logic signed [PROD1_W-1:0] mul1;
  logic signed [PROD_W-1:0]  prod0_r;
  logic signed [PROD1_W-1:0] prod1_r;
  shift_sel_t                sh2_r;
  logic signed [PROD_W-1:0]  half;
  logic signed [PROD_W-1:0]  sum_r;
  shift_sel_t                sh3_r;
  logic signed [PROD_W-1:0]  shifted;
  logic                      fits;

  always_comb begin
    m0   = op.m0;
    x0   = op.x0;
    m1   = op.m1;
    x1   = op.x1;
    mul0 = PROD_W'(m0) * PROD_W'(x0);
    mul1 = PROD1_W'(m1) * PROD1_W'(x1);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      prod0_r <= mul0;
      prod1_r <= mul1;
      sh2_r   <= op.sh;
    end
  end

  // Adding half an LSB before the arithmetic shift rounds half up.
  always_comb begin
    unique case (sh2_r)
      SH_NONE:  half = '0;
      SH_ROT:   half = PROD_W'(1) <<< (ROT_SHIFT - 1);
      SH_SCALE: half = PROD_W'(1) <<< (FRAC_BITS - 1);
      default:  half = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en_sum) begin
      sum_r <= prod0_r + PROD_W'(prod1_r) + half;
      sh3_r <= sh2_r;
    end
  end

  always_comb begin
    unique case (sh3_r)
      SH_NONE:  shifted = sum_r;
      SH_ROT:   shifted = sum_r >>> ROT_SHIFT;
      SH_SCALE: shifted = sum_r >>> FRAC_BITS;
      default:  shifted = sum_r;
    endcase
    fits = (&shifted[PROD_W-1:DATA_W-1]) || !(|shifted[PROD_W-1:DATA_W-1]);
    res.clip = !fits;
    if (fits) begin
      res.value = shifted[DATA_W-1:0];
    end else if (shifted[PROD_W-1]) begin
      res.value = DATA_MIN;
    end else begin
      res.value = DATA_MAX;
    end
  end

endmodule

### sv/vtu_merge.sv
module vtu_merge import vtu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     res_valid,
  input  lane_res_t                res_x,
  input  lane_res_t                res_y,
  input  lane_res_t                res_z,
  output logic                     ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_r_x,
  output logic signed [DATA_W-1:0] out_r_y,
  output logic signed [DATA_W-1:0] out_r_z,
  output logic                     out_saturated
);

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] r_x_r;
  logic signed [DATA_W-1:0] r_y_r;
  logic signed [DATA_W-1:0] r_z_r;
  logic                     sat_r;

  assign ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      r_x_r <= res_x.value;
      r_y_r <= res_y.value;
      r_z_r <= res_z.value;
      sat_r <= res_x.clip || res_y.clip || res_z.clip;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_r_x       = r_x_r;
  assign out_r_y       = r_y_r;
  assign out_r_z       = r_z_r;
  assign out_saturated = sat_r;

endmodule

### sv/vector3_transform_unit.sv
// Vector transform unit: add, subtract, scale or rotate a 3D Q16.16 vector.
//
// Input channel (in_*): one item per accepted edge (in_valid high, in_stall
// low) carries a command, vector A, vector B (or per-axis scale factors) and a
// binary angle where 65536 is a full turn. The angle is ignored unless the
// command is a rotation, and B is ignored for rotations.
// Result channel (out_*): one item per input item, in order, with the three
// saturated components and a flag that is set when any component clipped.
//
// The pipeline has four register stages: sine/cosine table lookup and operand
// capture, the lane multipliers, the lane adders, and the output register.
// Throughput is one item per cycle while the receiver does not stall; it is
// set by the three lanes, each with one full multiplier and one coefficient
// multiplier used once per item.
//
// When the receiver stalls, the held result stays in the output register and
// each stage behind it still fills as long as it holds a bubble, so in_stall
// rises only once the whole pipeline is full. Reset clears every stage's
// valid bit; no result is pending after reset and the table is a constant.
module vector3_transform_unit import vtu_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_a_x,
  input  logic signed [DATA_W-1:0] in_a_y,
  input  logic signed [DATA_W-1:0] in_a_z,
  input  logic signed [DATA_W-1:0] in_b_x,
  input  logic signed [DATA_W-1:0] in_b_y,
  input  logic signed [DATA_W-1:0] in_b_z,
  input  logic [ANGLE_W-1:0]       in_angle,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_r_x,
  output logic signed [DATA_W-1:0] out_r_y,
  output logic signed [DATA_W-1:0] out_r_z,
  output logic                     out_saturated
);

  // Stage valid bits and the ready chain from the output register backward.
  logic v1_r;
  logic v2_r;
  logic v3_r;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic merge_ready;

  // Stage 1 operand registers.
  logic [CMD_W-1:0]         cmd1_r;
  logic signed [DATA_W-1:0] ax1_r;
  logic signed [DATA_W-1:0] ay1_r;
  logic signed [DATA_W-1:0] az1_r;
  logic signed [DATA_W-1:0] bx1_r;
  logic signed [DATA_W-1:0] by1_r;
  logic signed [DATA_W-1:0] bz1_r;

  logic signed [COEF_W-1:0] s_q15;
  logic signed [COEF_W-1:0] c_q15;
  logic signed [DATA_W-1:0] s_ext;
  logic signed [DATA_W-1:0] c_ext;

  lane_op_t  op_x;
  lane_op_t  op_y;
  lane_op_t  op_z;
  lane_ctl_t lane_ctl;
  lane_res_t res_x;
  lane_res_t res_y;
  lane_res_t res_z;

  assign rdy3     = !v3_r || merge_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign lane_ctl.en_mul = rdy2;
  assign lane_ctl.en_sum = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1_r <= in_command;
      ax1_r  <= in_a_x;
      ay1_r  <= in_a_y;
      az1_r  <= in_a_z;
      bx1_r  <= in_b_x;
      by1_r  <= in_b_y;
      bz1_r  <= in_b_z;
    end
  end

  // The table read is registered alongside the stage 1 operands.
  vtu_sine_rom #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_sine_rom (
    .clk    (clk),
    .en     (rdy1),
    .angle  (in_angle),
    .sin_q15(s_q15),
    .cos_q15(c_q15)
  );

  assign s_ext = DATA_W'(s_q15);
  assign c_ext = DATA_W'(c_q15);

  // Each lane computes m0*x0 + m1*x1. A lane with nothing to do passes its A
  // component through as 1*a + 0, which can never clip, so the unused
  // commands return A with the flag clear.
  always_comb begin
    op_x = '{m0: DATA_ONE, x0: ax1_r, m1: '0, x1: '0, sh: SH_NONE};
    op_y = '{m0: DATA_ONE, x0: ay1_r, m1: '0, x1: '0, sh: SH_NONE};
    op_z = '{m0: DATA_ONE, x0: az1_r, m1: '0, x1: '0, sh: SH_NONE};
    unique case (cmd1_r)
      CMD_ADD: begin
        op_x.m1 = COEF_ONE;
        op_x.x1 = bx1_r;
        op_y.m1 = COEF_ONE;
        op_y.x1 = by1_r;
        op_z.m1 = COEF_ONE;
        op_z.x1 = bz1_r;
      end
      CMD_SUB: begin
        op_x.m1 = COEF_MINUS_ONE;
        op_x.x1 = bx1_r;
        op_y.m1 = COEF_MINUS_ONE;
        op_y.x1 = by1_r;
        op_z.m1 = COEF_MINUS_ONE;
        op_z.x1 = bz1_r;
      end
      CMD_ROT_XY: begin
        // x' = c*x - s*y, y' = s*x + c*y
        op_x = '{m0: c_ext, x0: ax1_r, m1: -s_q15, x1: ay1_r, sh: SH_ROT};
        op_y = '{m0: s_ext, x0: ax1_r, m1: c_q15, x1: ay1_r, sh: SH_ROT};
      end
      CMD_ROT_XZ: begin
        // x' = c*x + s*z, z' = c*z - s*x
        op_x = '{m0: c_ext, x0: ax1_r, m1: s_q15, x1: az1_r, sh: SH_ROT};
        op_z = '{m0: c_ext, x0: az1_r, m1: -s_q15, x1: ax1_r, sh: SH_ROT};
      end
      CMD_ROT_YZ: begin
        // y' = c*y - s*z, z' = s*y + c*z
        op_y = '{m0: c_ext, x0: ay1_r, m1: -s_q15, x1: az1_r, sh: SH_ROT};
        op_z = '{m0: s_ext, x0: ay1_r, m1: c_q15, x1: az1_r, sh: SH_ROT};
      end
      CMD_SCALE: begin
        op_x = '{m0: bx1_r, x0: ax1_r, m1: '0, x1: '0, sh: SH_SCALE};
        op_y = '{m0: by1_r, x0: ay1_r, m1: '0, x1: '0, sh: SH_SCALE};
        op_z = '{m0: bz1_r, x0: az1_r, m1: '0, x1: '0, sh: SH_SCALE};
      end
      default: begin
      end
    endcase
  end

  vtu_lane u_lane_x (
    .clk(clk),
    .ctl(lane_ctl),
    .op (op_x),
    .res(res_x)
  );

  vtu_lane u_lane_y (
    .clk(clk),
    .ctl(lane_ctl),
    .op (op_y),
    .res(res_y)
  );

  vtu_lane u_lane_z (
    .clk(clk),
    .ctl(lane_ctl),
    .op (op_z),
    .res(res_z)
  );

  // The output register joins the three lanes and ORs their clip flags.
  vtu_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (v3_r),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_z        (res_z),
    .ready        (merge_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_r_x      (out_r_x),
    .out_r_y      (out_r_y),
    .out_r_z      (out_r_z),
    .out_saturated(out_saturated)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the 3D vector transform unit.
// A table-driven predictor computes the expected result of every accepted item.
// A checker process compares each accepted result with the oldest expected one.
module tb;
  import vtu_pkg::*;

  // Bench timing and limits.
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  // The tail wait adds margin beyond the block's pipeline.
  localparam int PIPE_LATENCY = 3;
  localparam int TAIL_CYCLES  = PIPE_LATENCY + 8;
  // The longest correct quiet stretch is the long receiver hold of the back-pressure test.
  // The watchdog limit is far above it.
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int SINE_N       = SINE_TABLE_ENTRIES_DEF;

  // The block defines commands 0 to 5. The two spare codes pass A through.
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

  // One input item and one result item. The fields have the same widths as the ports.
  typedef struct {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] a_x, a_y, a_z;
    logic signed [DATA_W-1:0] b_x, b_y, b_z;
    logic [ANGLE_W-1:0]       angle;
  } vec_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] r_x, r_y, r_z;
    logic                     saturated;
  } vec_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command;
  logic signed [DATA_W-1:0] in_a_x, in_a_y, in_a_z;
  logic signed [DATA_W-1:0] in_b_x, in_b_y, in_b_z;
  logic [ANGLE_W-1:0]       in_angle;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_r_x, out_r_y, out_r_z;
  logic                     out_saturated;

  // The predictor's copy of the quarter-wave sine magnitudes, in unsigned Q1.15.
  logic [15:0] sine_mag [0:SINE_N];

  // Expected results, oldest first. Each one is pushed when its item is accepted.
  vec_result_t expected_results[$];
  int          mismatch_count;
  int          results_seen;

  // Controls shared by the sender, the receiver and the test tasks.
  bit tx_idle;
  bit rx_idle;
  int rx_hold_cycles;

  vector3_transform_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_a_z       (in_a_z),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_b_z       (in_b_z),
    .in_angle     (in_angle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_r_x      (out_r_x),
    .out_r_y      (out_r_y),
    .out_r_z      (out_r_z),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Build the sine table with a Taylor series in Q30. Pi/2 is taken as
  // 1686629713 / 2^30. Each entry is rounded half up to Q1.15 and clamped to 1.0.
  function automatic void build_sine_table();
    longint unsigned x, x2, term, r, n;
    longint          sum;
    int              k;
    for (k = 0; k <= SINE_N; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) / longint'(SINE_N);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (longint'(sum) + (64'd1 << 14)) >> 15;
      if (r > UNIT_Q15) begin
        r = UNIT_Q15;
      end
      sine_mag[k] = r[15:0];
    end
  endfunction

  // The top two angle bits select the quadrant. The remaining 14 bits are
  // scaled down to a table index and truncated. Odd quadrants read the table
  // backwards, and the upper half of the turn is negated.
  function automatic longint sine_q15(input logic [ANGLE_W-1:0] ang);
    int     idx;
    longint mag;
    idx = (int'(ang[13:0]) * SINE_N) >> 14;
    if (ang[14]) begin
      mag = longint'(sine_mag[SINE_N - idx]);
    end else begin
      mag = longint'(sine_mag[idx]);
    end
    return ang[15] ? -mag : mag;
  endfunction

  // Add half an LSB, then shift right arithmetically, which rounds half up.
  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [DATA_W-1:0] clip_to_word(input longint v, inout bit sat);
    if (v > longint'(DATA_MAX)) begin
      sat = 1'b1;
      return DATA_MAX;
    end else if (v < longint'(DATA_MIN)) begin
      sat = 1'b1;
      return DATA_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  // All arithmetic uses 64-bit signed values. Every sum of products here fits in 64 bits.
  function automatic vec_result_t transform_vector(input vec_item_t it);
    longint      ax, ay, az, bx, by, bz, s, c, rx, ry, rz;
    bit          sat;
    vec_result_t res;
    ax  = it.a_x;  ay = it.a_y;  az = it.a_z;
    bx  = it.b_x;  by = it.b_y;  bz = it.b_z;
    s   = sine_q15(it.angle);
    c   = sine_q15(it.angle + QUARTER_TURN);
    rx  = ax;  ry = ay;  rz = az;
    sat = 1'b0;
    case (it.command)
      CMD_ADD: begin
        rx = ax + bx;  ry = ay + by;  rz = az + bz;
      end
      CMD_SUB: begin
        rx = ax - bx;  ry = ay - by;  rz = az - bz;
      end
      CMD_ROT_XY: begin
        rx = round_half_up(c * ax - s * ay, ROT_SHIFT);
        ry = round_half_up(s * ax + c * ay, ROT_SHIFT);
      end
      CMD_ROT_XZ: begin
        rx = round_half_up(c * ax + s * az, ROT_SHIFT);
        rz = round_half_up(c * az - s * ax, ROT_SHIFT);
      end
      CMD_ROT_YZ: begin
        ry = round_half_up(c * ay - s * az, ROT_SHIFT);
        rz = round_half_up(s * ay + c * az, ROT_SHIFT);
      end
      CMD_SCALE: begin
        rx = round_half_up(ax * bx, FRAC_BITS);
        ry = round_half_up(ay * by, FRAC_BITS);
        rz = round_half_up(az * bz, FRAC_BITS);
      end
      default: begin
        // The spare codes return A unchanged and never saturate.
      end
    endcase
    res.r_x       = clip_to_word(rx, sat);
    res.r_y       = clip_to_word(ry, sat);
    res.r_z       = clip_to_word(rz, sat);
    res.saturated = sat;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item construction
  // ---------------------------------------------------------------------------

  function automatic vec_item_t make_item(
    input logic [CMD_W-1:0] cmd,
    input logic signed [DATA_W-1:0] ax, ay, az, bx, by, bz,
    input logic [ANGLE_W-1:0] ang
  );
    vec_item_t it;
    it.command = cmd;
    it.a_x = ax;  it.a_y = ay;  it.a_z = az;
    it.b_x = bx;  it.b_y = by;  it.b_z = bz;
    it.angle = ang;
    return it;
  endfunction

  // Components are weighted toward the rails and small magnitudes. This makes
  // saturation and rounding common. The rest are uniform over the full word.
  function automatic logic signed [DATA_W-1:0] random_component();
    case ($urandom_range(0, 9))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2: return DATA_W'($urandom_range(0, 262144)) - 32'sd131072;
      3: return $urandom_range(0, 1) ? ONE_Q16 : -ONE_Q16;
      4: return DATA_MAX - DATA_W'($urandom_range(0, 255));
      5: return DATA_MIN + DATA_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_item_t random_vector();
    vec_item_t it;
    int        pick;
    pick = $urandom_range(0, 39);
    if (pick == 0) begin
      it.command = CMD_SPARE6;
    end else if (pick == 1) begin
      it.command = CMD_SPARE7;
    end else begin
      it.command = CMD_W'(pick % 6);
    end
    it.a_x = random_component();
    it.a_y = random_component();
    it.a_z = random_component();
    it.b_x = random_component();
    it.b_y = random_component();
    it.b_z = random_component();
    // Some angles land on a quadrant boundary or one step to either side of it.
    if ($urandom_range(0, 3) == 0) begin
      it.angle = ANGLE_W'({$urandom_range(0, 3), 14'd0} + $urandom_range(0, 2) - 1);
    end else begin
      it.angle = ANGLE_W'($urandom);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until the block accepts it. Valid stays high
  // after acceptance, so back-to-back items never drop and raise valid within
  // one time step. Valid is lowered when a gap is drawn or when the sender
  // waits for the backlog to drain.
  task automatic send_vector(input vec_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= it.command;
    in_a_x     <= it.a_x;
    in_a_y     <= it.a_y;
    in_a_z     <= it.a_z;
    in_b_x     <= it.b_x;
    in_b_y     <= it.b_y;
    in_b_z     <= it.b_z;
    in_angle   <= it.angle;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_results.push_back(transform_vector(it));
  endtask

  // The sender stops offering and pauses here until the block has returned
  // everything it owes. It waits on the clock even when nothing is owed.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: drives out_stall. Before each result it draws a hold-off. A long
  // hold requested by a test is taken in place of the next draw.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        hold = rx_idle ? $urandom_range(0, 19) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every accepted result is compared field by field with the oldest
  // expected result. A result with nothing expected is also a failure.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    vec_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("result %0d: unexpected, got x=%h y=%h z=%h sat=%b", results_seen,
                   out_r_x, out_r_y, out_r_z, out_saturated);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_r_x !== want.r_x || out_r_y !== want.r_y || out_r_z !== want.r_z ||
            out_saturated !== want.saturated) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                     results_seen, want.r_x, want.r_y, want.r_z, want.saturated,
                     out_r_x, out_r_y, out_r_z, out_saturated);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0) ||
          (out_valid === 1'b1 && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Add and subtract at the rails. Results overflow in both directions, and
  // one plain sum is included.
  task automatic test_add_sub_extremes();
    send_vector(make_item(CMD_ADD, DATA_MAX, DATA_MIN, 32'sd0, DATA_ONE, -DATA_ONE, 32'sd0,
                          16'd0));
    send_vector(make_item(CMD_ADD, DATA_MAX, DATA_MIN, ONE_Q16, DATA_MAX, DATA_MIN, -ONE_Q16,
                          16'hFFFF));
    send_vector(make_item(CMD_SUB, DATA_MIN, DATA_MAX, 32'sd0, DATA_MAX, DATA_MIN, DATA_MIN,
                          16'h8000));
    send_vector(make_item(CMD_SUB, DATA_MAX, 32'sd5, DATA_MIN, -DATA_ONE, 32'sd7, DATA_ONE,
                          16'h1234));
    send_vector(make_item(CMD_ADD, 32'sh1234_5678, -32'sh0FED_CBA9, 32'sd0, 32'sh0101_0101,
                          32'sh0202_0202, -32'sd1, 16'h4000));
  endtask

  // Rotations in all three planes. The angles include zero, a quarter turn, a half turn,
  // the last angle before a full turn, and an eighth turn. At an eighth turn, rail
  // inputs overflow the rotated components. At a half turn, the most negative word
  // negates past the top of the range.
  task automatic test_rotations_directed();
    send_vector(make_item(CMD_ROT_XY, DATA_MAX, DATA_MIN, 32'sd9, 32'sd0, 32'sd0, 32'sd0,
                          16'd8192));
    send_vector(make_item(CMD_ROT_XY, ONE_Q16, 32'sd0, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MAX,
                          QUARTER_TURN));
    send_vector(make_item(CMD_ROT_XY, DATA_MIN, DATA_MIN, DATA_MAX, 32'sd0, 32'sd0, 32'sd0,
                          16'd0));
    send_vector(make_item(CMD_ROT_XZ, DATA_MIN, 32'sd3, DATA_MAX, 32'sd0, 32'sd0, 32'sd0,
                          16'd57344));
    send_vector(make_item(CMD_ROT_XZ, ONE_Q16, DATA_MAX, -ONE_Q16, 32'sd0, 32'sd0, 32'sd0,
                          16'hFFFF));
    send_vector(make_item(CMD_ROT_XZ, DATA_MIN, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0,
                          16'h8000));
    send_vector(make_item(CMD_ROT_YZ, 32'sd77, DATA_MIN, DATA_MIN, 32'sd0, 32'sd0, 32'sd0,
                          16'h8000));
    send_vector(make_item(CMD_ROT_YZ, DATA_MIN, DATA_MAX, DATA_MAX, 32'sd0, 32'sd0, 32'sd0,
                          16'd24576));
    send_vector(make_item(CMD_ROT_YZ, 32'sd0, 32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0,
                          16'd1));
  endtask

  // Scale cases: the most negative word squared saturates high, and a unit
  // scale is exact. Tiny products exercise round half up on both signs.
  task automatic test_scale_directed();
    send_vector(make_item(CMD_SCALE, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN,
                          16'd0));
    send_vector(make_item(CMD_SCALE, 32'sh0123_4567, -32'sh0765_4321, DATA_MIN, ONE_Q16,
                          ONE_Q16, ONE_Q16, 16'hFFFF));
    send_vector(make_item(CMD_SCALE, -DATA_ONE, 32'sd32768, -32'sd32768, DATA_ONE, DATA_ONE,
                          DATA_ONE, 16'h4000));
    send_vector(make_item(CMD_SCALE, DATA_MAX, 32'sd98304, -32'sd98304, -ONE_Q16, 32'sd1,
                          32'sd1, 16'h8000));
    send_vector(make_item(CMD_SCALE, 32'sd0, DATA_MIN, 32'sh7FFF_0000, DATA_MAX, -ONE_Q16,
                          32'sh0002_0000, 16'h1000));
  endtask

  // The two spare command codes must return A untouched with the flag clear.
  task automatic test_spare_commands();
    send_vector(make_item(CMD_SPARE6, DATA_MAX, DATA_MIN, 32'sh5A5A_A5A5, DATA_MAX, DATA_MAX,
                          DATA_MAX, 16'h2000));
    send_vector(make_item(CMD_SPARE7, DATA_MIN, DATA_MAX, -32'sd1, DATA_MIN, DATA_MIN, DATA_MIN,
                          16'hC000));
  endtask

  // The bulk of the run: random items, with random idling on both sides.
  task automatic test_random_mix(input int count);
    int i;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (i = 0; i < count; i++) begin
      send_vector(random_vector());
    end
  endtask

  // The receiver holds off for a long stretch while the sender offers items
  // without gaps. The pipeline fills and must stall its input. Then the sender
  // waits for the backlog to drain.
  task automatic test_back_pressure(input int count);
    int i;
    wait_results_drained();
    tx_idle        = 1'b0;
    rx_hold_cycles = 100;
    for (i = 0; i < count; i++) begin
      send_vector(random_vector());
    end
    tx_idle = 1'b1;
    wait_results_drained();
  endtask

  // A stretch with no idling on either side, at the full rate of one item per cycle.
  task automatic test_streaming(input int count);
    int i;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (i = 0; i < count; i++) begin
      send_vector(random_vector());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    mismatch_count = 0;
    results_seen   = 0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    rx_hold_cycles = 0;
    build_sine_table();

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= '0;
    in_a_x     <= '0;
    in_a_y     <= '0;
    in_a_z     <= '0;
    in_b_x     <= '0;
    in_b_y     <= '0;
    in_b_z     <= '0;
    in_angle   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_add_sub_extremes();
    test_rotations_directed();
    test_scale_directed();
    test_spare_commands();
    test_random_mix(700);
    test_back_pressure(60);
    test_streaming(240);
    test_random_mix(400);

    // All items are in. Wait for the block to return everything, then leave a
    // short tail so that a stray extra result would still be caught.
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
